// ----- rtl/idmt_pkg.sv -----
`timescale 1ns / 1ps

package idmt_pkg;

	localparam int PHASES        = 4;
	localparam int CURRENT_BITS  = 16;
	localparam int PH_W          = $clog2(PHASES);
	localparam int DT_BITS       = 20;
	localparam int FLAG_BITS     = 4;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;
	localparam int FRAC_BITS     = 30;
	localparam int LOG_STEPS     = 30;
	localparam int EXP_STEPS     = 30;
	localparam int DIV_BITS      = 64;
	localparam int NEAR_NUM      = 10001;
	localparam int NEAR_DEN      = 10000;

	localparam logic [31:0] US_PER_S = 32'd1000000;
	localparam logic [63:0] PROG_ONE = 64'h0000_0000_8000_0000;

	localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EXPONENT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TMS      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX      = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE   = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PICKUP   = 3'd6;

	localparam logic [23:0] CURVE_RST    = 24'd9175;
	localparam logic [19:0] EXPONENT_RST = 20'd1311;
	localparam logic [19:0] TMS_RST      = 20'd65536;

	typedef logic [31:0] root_tab_t [EXP_STEPS];

	typedef enum logic [4:0] {
		S_IDLE,
		S_PHASE,
		S_LOG,
		S_LDIFF,
		S_E_LO,
		S_E_HI,
		S_EXP,
		S_DENOM,
		S_N_MUL,
		S_N_LO,
		S_N_HI,
		S_T_GO,
		S_T_WAIT,
		S_CLAMP,
		S_I_GO,
		S_I_WAIT,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] num;
		logic [DIV_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_BITS-1:0] quot;
	} div_rsp_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bitv;
		v   = v_in;
		res = '0;
		for (int j = 31; j >= 0; j--) begin
			bitv = 64'd1 << (2 * j);
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// successive square roots of two, Q2.30
	function automatic root_tab_t exp_roots();
		root_tab_t   tab;
		logic [63:0] c;
		c = 64'd2 << FRAC_BITS;
		for (int k = 0; k < EXP_STEPS; k++) begin
			c      = isqrt64(c << FRAC_BITS);
			tab[k] = c[31:0];
		end
		return tab;
	endfunction

	localparam root_tab_t EXP_ROOT = exp_roots();

endpackage

// ----- rtl/idmt_if.sv -----
`timescale 1ns / 1ps

interface idmt_in_if;
	import idmt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CURRENT_BITS-1:0] current_a;
	logic [CURRENT_BITS-1:0] current_b;
	logic [CURRENT_BITS-1:0] current_c;
	logic [CURRENT_BITS-1:0] current_n;
	logic [DT_BITS-1:0]      dt_us;

	modport source (output valid, current_a, current_b, current_c, current_n, dt_us,
		input ready);
	modport sink (input valid, current_a, current_b, current_c, current_n, dt_us,
		output ready);
endinterface

interface idmt_out_if;
	import idmt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [FLAG_BITS-1:0] start_flags;
	logic [FLAG_BITS-1:0] trip_flags;

	modport source (output valid, start_flags, trip_flags, input ready);
	modport sink (input valid, start_flags, trip_flags, output ready);
endinterface

// ----- rtl/idmt_mul.sv -----
`timescale 1ns / 1ps

module idmt_mul (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod
);
	assign prod = 64'(a) * 64'(b);
endmodule

// ----- rtl/idmt_div.sv -----
`timescale 1ns / 1ps

module idmt_div (
	input  logic               clk,
	input  logic               arst_n,
	input  idmt_pkg::div_req_t req,
	output idmt_pkg::div_rsp_t rsp
);
	import idmt_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [5:0]          cnt_q;
	logic [DIV_BITS-1:0] num_q;
	logic [DIV_BITS-1:0] rem_q;
	logic [DIV_BITS-1:0] den_q;
	logic [DIV_BITS:0]   trial;
	logic [DIV_BITS:0]   diff;
	logic                ge;

	assign trial = {rem_q, num_q[DIV_BITS-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
			num_q <= {num_q[DIV_BITS-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;
endmodule

// ----- rtl/idmt_overcurrent_relay.sv -----
`timescale 1ns / 1ps
// Inverse-time overcurrent element for four phases (A, B, C, neutral).
// frame carries one measurement item: four current magnitudes and the
// microseconds elapsed since the previous item. result carries one item
// back per frame: start flags (current at or above pickup) and trip flags
// (progress towards operate reached one during this frame).
// The user must write settings (cfg_we/cfg_index/cfg_data) only while no
// frame is in work; the block does not enforce this. Each phase is handled in
// turn by one shared 32x32 multiplier (log2 by squaring, exponent product,
// 2^x by root products, time constant) and one radix-2 64-bit divider
// (operate time, then progress step); a phase that is disabled, below pickup
// or near one skips both.
// frame.ready is high only while no frame is in work; a finished result sits
// in an output register, so the next frame may be taken while it waits.
// If result.ready stays low, the following frame completes and then waits.
// Reset clears all progress, drops any pending result and loads the default
// settings.

module idmt_overcurrent_relay (
	input  logic                                 clk,
	input  logic                                 arst_n,
	idmt_in_if.sink                              frame,
	idmt_out_if.source                           result,
	input  logic                                 cfg_we,
	input  logic [idmt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [idmt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import idmt_pkg::*;

	fsm_t state_q, state_d;

	logic [23:0] curve_q;
	logic [19:0] expo_q;
	logic [19:0] tms_q;
	logic [31:0] min_q;
	logic [31:0] max_q;
	logic [PHASES-1:0] en_q;
	logic [PHASES-1:0][CURRENT_BITS-1:0] pickup_q;

	logic [PH_W-1:0]         ph_q;
	logic [CURRENT_BITS-1:0] cur_q [PHASES];
	logic [DT_BITS-1:0]      dt_q;
	logic [PHASES-1:0]       start_q;
	logic [PHASES-1:0]       trip_q;
	logic [31:0]             progress_q [PHASES];

	logic [31:0] y_q;
	logic [29:0] f_q;
	logic [3:0]  lead_q;
	logic [4:0]  cnt_q;
	logic        which_q;
	logic [33:0] li_q;
	logic [33:0] lp_q;
	logic [33:0] l_q;
	logic [63:0] acc_q;
	logic [38:0] e_q;
	logic [31:0] r_q;
	logic [63:0] d_q;
	logic [63:0] n_q;
	logic [63:0] t_q;

	logic                 out_valid_q;
	logic [FLAG_BITS-1:0] out_start_q;
	logic [FLAG_BITS-1:0] out_trip_q;

	logic                    accept;
	logic [CURRENT_BITS-1:0] cur_sel;
	logic [CURRENT_BITS-1:0] pick_sel;
	logic                    below;
	logic                    near_one;
	logic                    no_curve;
	logic [29:0]             cur_x;
	logic [29:0]             pick_x;
	logic [CURRENT_BITS-1:0] norm_src;
	logic [3:0]              lead;
	logic [31:0]             y_norm;
	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic [63:0]             prod;
	logic [32:0]             sq;
	logic                    ov;
	logic [31:0]             y_next;
	logic [29:0]             f_next;
	logic [33:0]             log_val;
	logic [63:0]             e_sum;
	logic [38:0]             e_new;
	logic [5:0]              shamt;
	logic [63:0]             d_new;
	logic [63:0]             t1;
	logic [63:0]             t2;
	logic [63:0]             t3;
	logic [63:0]             p_sum;
	logic                    last_ph;
	logic                    advance;
	logic                    load_log;
	logic                    out_load;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	idmt_mul u_mul (
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	idmt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept       = frame.valid && frame.ready;
	assign frame.ready  = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.start_flags = out_start_q;
	assign result.trip_flags  = out_trip_q;

	assign cur_sel  = cur_q[ph_q];
	assign pick_sel = pickup_q[ph_q];
	assign below    = (pick_sel == '0) || (cur_sel < pick_sel);
	assign cur_x    = 30'(cur_sel) * 30'(NEAR_DEN);
	assign pick_x   = 30'(pick_sel) * 30'(NEAR_NUM);
	assign near_one = cur_x <= pick_x;
	assign no_curve = (curve_q == '0) || (expo_q == '0) || (tms_q == '0);
	assign last_ph  = (ph_q == PH_W'(PHASES - 1));

	assign norm_src = (state_q == S_PHASE) ? cur_sel : pick_sel;

	always_comb begin
		lead = '0;
		for (int i = 0; i < CURRENT_BITS; i++) begin
			if (norm_src[i]) lead = 4'(i);
		end
	end

	assign y_norm = 32'(norm_src) << (5'd31 - {1'b0, lead});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_LOG: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			S_E_LO: begin
				mul_a = 32'(expo_q);
				mul_b = l_q[31:0];
			end
			S_E_HI: begin
				mul_a = 32'(expo_q);
				mul_b = 32'(l_q[33:32]);
			end
			S_EXP: begin
				mul_a = r_q;
				mul_b = EXP_ROOT[cnt_q];
			end
			S_N_MUL: begin
				mul_a = 32'(curve_q);
				mul_b = 32'(tms_q);
			end
			S_N_LO: begin
				mul_a = acc_q[31:0];
				mul_b = US_PER_S;
			end
			S_N_HI: begin
				mul_a = 32'(acc_q[43:32]);
				mul_b = US_PER_S;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign sq      = prod[63:31];
	assign ov      = sq[32];
	assign y_next  = ov ? sq[32:1] : sq[31:0];
	assign f_next  = {f_q[28:0], ov};
	assign log_val = {lead_q, f_next};

	assign e_sum = acc_q + {prod[31:0], 32'd0};
	assign e_new = e_sum[54:16];

	assign shamt = 6'(e_q[34:30]) + 6'd2;
	assign d_new = (64'(r_q) << shamt) - 64'h0000_0001_0000_0000;

	assign t1 = (t_q == '0) ? 64'd1 : t_q;
	assign t2 = ((min_q != '0) && (t1 < 64'(min_q))) ? 64'(min_q) : t1;
	assign t3 = ((max_q != '0) && (t2 > 64'(max_q))) ? 64'(max_q) : t2;

	assign p_sum = 64'(progress_q[ph_q]) + div_rsp.quot;

	always_comb begin
		div_req.start = (state_q == S_T_GO) || (state_q == S_I_GO);
		div_req.num   = (state_q == S_I_GO) ? (64'(dt_q) << 31) : n_q;
		div_req.den   = (state_q == S_I_GO) ? t_q : d_q;
	end

	always_comb begin
		state_d  = state_q;
		advance  = 1'b0;
		load_log = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_PHASE;
			end
			S_PHASE: begin
				if (!en_q[ph_q] || below || near_one || no_curve) begin
					advance = 1'b1;
				end else begin
					load_log = 1'b1;
					state_d  = S_LOG;
				end
			end
			S_LOG: begin
				if (cnt_q == 5'(LOG_STEPS - 1) && which_q) state_d = S_LDIFF;
			end
			S_LDIFF: state_d = S_E_LO;
			S_E_LO:  state_d = S_E_HI;
			S_E_HI: begin
				if (e_new == '0) advance = 1'b1;
				else if (e_new[38:35] != '0) state_d = S_CLAMP;
				else state_d = S_EXP;
			end
			S_EXP: begin
				if (cnt_q == 5'(EXP_STEPS - 1)) state_d = S_DENOM;
			end
			S_DENOM: begin
				if (d_new == '0) advance = 1'b1;
				else state_d = S_N_MUL;
			end
			S_N_MUL: state_d = S_N_LO;
			S_N_LO:  state_d = S_N_HI;
			S_N_HI:  state_d = S_T_GO;
			S_T_GO:  state_d = S_T_WAIT;
			S_T_WAIT: begin
				if (div_rsp.done) state_d = S_CLAMP;
			end
			S_CLAMP: state_d = S_I_GO;
			S_I_GO:  state_d = S_I_WAIT;
			S_I_WAIT: begin
				if (div_rsp.done) advance = 1'b1;
			end
			S_DONE: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (advance) state_d = last_ph ? S_DONE : S_PHASE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) ph_q <= '0;
			else if (advance && !last_ph) ph_q <= ph_q + PH_W'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_q  <= CURVE_RST;
			expo_q   <= EXPONENT_RST;
			tms_q    <= TMS_RST;
			min_q    <= '0;
			max_q    <= '0;
			en_q     <= '0;
			pickup_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CURVE:    curve_q  <= cfg_data[23:0];
				CFG_EXPONENT: expo_q   <= cfg_data[19:0];
				CFG_TMS:      tms_q    <= cfg_data[19:0];
				CFG_MIN:      min_q    <= cfg_data[31:0];
				CFG_MAX:      max_q    <= cfg_data[31:0];
				CFG_ENABLE:   en_q     <= cfg_data[PHASES-1:0];
				CFG_PICKUP:   pickup_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PHASES; i++) progress_q[i] <= '0;
		end else if (state_q == S_PHASE && en_q[ph_q] && below) begin
			progress_q[ph_q] <= '0;
		end else if (state_q == S_I_WAIT && div_rsp.done) begin
			progress_q[ph_q] <= (p_sum >= PROG_ONE) ? PROG_ONE[31:0] : p_sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q[0] <= frame.current_a;
			cur_q[1] <= frame.current_b;
			cur_q[2] <= frame.current_c;
			cur_q[3] <= frame.current_n;
			dt_q     <= frame.dt_us;
			start_q  <= '0;
			trip_q   <= '0;
		end
		if (state_q == S_PHASE && en_q[ph_q] && !below) start_q[ph_q] <= 1'b1;
		if (state_q == S_I_WAIT && div_rsp.done && p_sum >= PROG_ONE) trip_q[ph_q] <= 1'b1;
		if (out_load) begin
			out_start_q <= start_q;
			out_trip_q  <= trip_q;
		end
		if (load_log) begin
			y_q     <= y_norm;
			lead_q  <= lead;
			f_q     <= '0;
			cnt_q   <= '0;
			which_q <= 1'b0;
		end
		case (state_q)
			S_LOG: begin
				if (cnt_q == 5'(LOG_STEPS - 1)) begin
					if (!which_q) begin
						li_q    <= log_val;
						y_q     <= y_norm;
						lead_q  <= lead;
						f_q     <= '0;
						cnt_q   <= '0;
						which_q <= 1'b1;
					end else begin
						lp_q <= log_val;
					end
				end else begin
					y_q   <= y_next;
					f_q   <= f_next;
					cnt_q <= cnt_q + 5'd1;
				end
			end
			S_LDIFF: l_q <= (li_q > lp_q) ? li_q - lp_q : '0;
			S_E_LO:  acc_q <= prod;
			S_E_HI: begin
				e_q   <= e_new;
				t_q   <= '0;
				r_q   <= 32'd1 << FRAC_BITS;
				cnt_q <= '0;
			end
			S_EXP: begin
				if (e_q[5'(EXP_STEPS - 1) - cnt_q]) r_q <= prod[61:30];
				cnt_q <= cnt_q + 5'd1;
			end
			S_DENOM: d_q <= d_new;
			S_N_MUL: acc_q <= prod;
			S_N_LO:  n_q <= prod;
			S_N_HI:  n_q <= n_q + {prod[31:0], 32'd0};
			S_T_WAIT: begin
				if (div_rsp.done) t_q <= div_rsp.quot;
			end
			S_CLAMP: t_q <= t3;
			default: ;
		endcase
	end

	a_progress_cap: assert property (@(posedge clk) disable iff (!arst_n)
		progress_q[ph_q] <= PROG_ONE[31:0])
		else $error("progress above one");

	a_trip_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.trip_flags & ~result.start_flags) == '0))
		else $error("trip flag without start flag");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_T_WAIT || state_q == S_I_WAIT))
		else $error("divider result outside a wait state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_PHASE && ph_q == '0))
		else $error("accepted item not started at first phase");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_valid_q) |=> out_valid_q)
		else $error("finished item not presented");
endmodule

// ----- tb/idmt_overcurrent_relay_tb.sv -----
`timescale 1ns / 1ps

module idmt_overcurrent_relay_tb;
	import idmt_pkg::*;

	typedef struct {
		logic [FLAG_BITS-1:0] start_flags;
		logic [FLAG_BITS-1:0] trip_flags;
	} flags_t;

	class relay_scoreboard;
		logic [23:0] curve;
		logic [19:0] expo;
		logic [19:0] tms;
		logic [31:0] min_us;
		logic [31:0] max_us;
		logic [3:0]  enables;
		logic [63:0] pickups;
		logic [63:0] progress [PHASES];
		logic [63:0] roots [EXP_STEPS+1];
		flags_t      pending [$];
		int          errors;

		function new();
			logic [63:0] c;
			curve   = CURVE_RST;
			expo    = EXPONENT_RST;
			tms     = TMS_RST;
			min_us  = '0;
			max_us  = '0;
			enables = '0;
			pickups = '0;
			errors  = 0;
			foreach (progress[i]) progress[i] = '0;
			c = 64'd2 << FRAC_BITS;
			for (int k = 1; k <= EXP_STEPS; k++) begin
				c = floor_root(c << FRAC_BITS);
				roots[k] = c;
			end
		endfunction

		function logic [63:0] floor_root(logic [63:0] v);
			logic [63:0] r;
			logic [63:0] t;
			r = '0;
			for (int j = 31; j >= 0; j--) begin
				t = r | (64'd1 << j);
				if (t * t <= v) r = t;
			end
			return r;
		endfunction

		function logic [63:0] log2_fix(logic [63:0] x);
			int          n;
			logic [63:0] y;
			logic [63:0] f;
			n = 31;
			f = '0;
			if (x == 0) return '0;
			while (x[n] == 1'b0) n--;
			y = x << (31 - n);
			for (int i = 0; i < FRAC_BITS; i++) begin
				y = (y * y) >> 31;
				f = f << 1;
				if (y >= (64'd1 << 32)) begin
					f[0] = 1'b1;
					y = y >> 1;
				end
			end
			return (64'(n) << FRAC_BITS) | f;
		endfunction

		function logic [63:0] pow2_frac(logic [63:0] frac);
			logic [63:0] r;
			r = 64'd1 << FRAC_BITS;
			for (int k = 1; k <= FRAC_BITS; k++)
				if (frac[FRAC_BITS-k]) r = (r * roots[k]) >> FRAC_BITS;
			return r;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
			case (idx)
				CFG_CURVE:    curve   = data[23:0];
				CFG_EXPONENT: expo    = data[19:0];
				CFG_TMS:      tms     = data[19:0];
				CFG_MIN:      min_us  = data[31:0];
				CFG_MAX:      max_us  = data[31:0];
				CFG_ENABLE:   enables = data[3:0];
				CFG_PICKUP:   pickups = data;
				default: ;
			endcase
		endfunction

		function void note_frame(logic [CURRENT_BITS-1:0] cur_in [PHASES], logic [DT_BITS-1:0] dt);
			flags_t      f;
			logic [63:0] cur, pick, li, lp, l, e, ip, r, d, n, t, inc;
			f.start_flags = '0;
			f.trip_flags  = '0;
			for (int i = 0; i < PHASES; i++) begin
				cur  = 64'(cur_in[i]);
				pick = 64'(pickups[i*CURRENT_BITS +: CURRENT_BITS]);
				if (!enables[i]) continue;
				if (pick == 0 || cur < pick) begin
					progress[i] = '0;
					continue;
				end
				f.start_flags[i] = 1'b1;
				if (cur * NEAR_DEN <= pick * NEAR_NUM) continue;
				if (expo == 0 || curve == 0 || tms == 0) continue;
				li = log2_fix(cur);
				lp = log2_fix(pick);
				l  = li > lp ? li - lp : 64'd0;
				e  = (64'(expo) * l) >> 16;
				if (e == 0) continue;
				ip = e >> FRAC_BITS;
				n  = 64'(curve) * 64'(tms) * 64'(US_PER_S);
				if (ip >= 32) begin
					t = '0;
				end else begin
					r = pow2_frac(e & ((64'd1 << FRAC_BITS) - 1));
					d = (r << (ip + 2)) - (64'd1 << 32);
					if (d == 0) continue;
					t = n / d;
				end
				if (t == 0) t = 64'd1;
				if (min_us != 0 && t < 64'(min_us)) t = 64'(min_us);
				if (max_us != 0 && t > 64'(max_us)) t = 64'(max_us);
				inc = (64'(dt) << 31) / t;
				if (progress[i] + inc >= PROG_ONE) begin
					progress[i] = PROG_ONE;
					f.trip_flags[i] = 1'b1;
				end else begin
					progress[i] = progress[i] + inc;
				end
			end
			pending.push_back(f);
		endfunction

		function void check_result(logic [FLAG_BITS-1:0] s, logic [FLAG_BITS-1:0] tr);
			flags_t f;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result start=%h trip=%h", $time, s, tr);
				errors++;
				return;
			end
			f = pending.pop_front();
			if (s !== f.start_flags) begin
				$display("%0t: start_flags expected %h actual %h", $time, f.start_flags, s);
				errors++;
			end
			if (tr !== f.trip_flags) begin
				$display("%0t: trip_flags expected %h actual %h", $time, f.trip_flags, tr);
				errors++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	idmt_in_if  frame_if ();
	idmt_out_if result_if ();

	idmt_overcurrent_relay DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	relay_scoreboard sb;
	bit              steady;
	int              hold_off;
	logic [15:0]     pick_now [PHASES];

	always #10 clk = ~clk;

	initial begin
		#200_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_if.valid && result_if.ready)
				sb.check_result(result_if.start_flags, result_if.trip_flags);
			if (hold_off > 0) begin
				result_if.ready <= 1'b0;
				hold_off <= hold_off - 1;
			end else begin
				result_if.ready <= steady || ($urandom_range(99) >= 20);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		if (idx == CFG_PICKUP)
			for (int i = 0; i < PHASES; i++) pick_now[i] = data[i*16 +: 16];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		frame_if.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_frame(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] n,
			logic [19:0] dt);
		logic [CURRENT_BITS-1:0] cur [PHASES];
		if (!steady && $urandom_range(99) < 20) begin
			frame_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
		frame_if.valid     <= 1'b1;
		frame_if.current_a <= a;
		frame_if.current_b <= b;
		frame_if.current_c <= c;
		frame_if.current_n <= n;
		frame_if.dt_us     <= dt;
		do @(posedge clk); while (!frame_if.ready);
		cur[0] = a;
		cur[1] = b;
		cur[2] = c;
		cur[3] = n;
		sb.note_frame(cur, dt);
	endtask

	function automatic logic [15:0] pick_current(logic [15:0] p);
		int m;
		m = $urandom_range(9);
		if (m == 0) return 16'($urandom);
		if (m == 1) return p == 0 ? 16'd0 : 16'($urandom_range(p - 1));
		if (m == 2) return p + 16'($urandom_range(p / 8000 + 1));
		if (m == 3) return p;
		return (int'(p) * ($urandom_range(40) + 10) / 10 > 65535) ? 16'hFFFF
			: 16'(int'(p) * ($urandom_range(40) + 10) / 10);
	endfunction

	function automatic logic [19:0] pick_dt();
		int m;
		m = $urandom_range(19);
		if (m == 0) return 20'd0;
		if (m == 1) return 20'hFFFFF;
		if (m < 5) return 20'($urandom);
		return 20'($urandom_range(200000, 1000));
	endfunction

	task automatic random_settings();
		logic [63:0] pk;
		int          m;
		m = $urandom_range(9);
		write_reg(CFG_CURVE, m == 0 ? 64'd0 : m == 1 ? 64'hFFFFFF :
			m < 5 ? 64'($urandom_range(24'hFFFFFF)) : 64'($urandom_range(900000, 5000)));
		m = $urandom_range(9);
		write_reg(CFG_EXPONENT, m == 0 ? 64'd0 : m == 1 ? 64'hFFFFF :
			m < 4 ? 64'($urandom_range(20'hFFFFF)) : 64'($urandom_range(150000, 1000)));
		m = $urandom_range(9);
		write_reg(CFG_TMS, m == 0 ? 64'd0 : m == 1 ? 64'hFFFFF :
			64'($urandom_range(20'hFFFFF, 3000)));
		m = $urandom_range(5);
		write_reg(CFG_MIN, m < 2 ? 64'd0 : m == 2 ? 64'hFFFF_FFFF : 64'($urandom_range(3000000)));
		m = $urandom_range(5);
		write_reg(CFG_MAX, m < 2 ? 64'd0 : m == 2 ? 64'hFFFF_FFFF : 64'($urandom));
		write_reg(CFG_ENABLE, $urandom_range(7) == 0 ? 64'($urandom_range(15)) : 64'hF);
		for (int i = 0; i < PHASES; i++) begin
			m = $urandom_range(9);
			pk[i*16 +: 16] = m == 0 ? 16'd0 : m == 1 ? 16'($urandom_range(15, 1)) :
				m == 2 ? 16'hFFFF : 16'($urandom);
		end
		write_reg(CFG_PICKUP, pk);
	endtask

	initial begin
		sb                 = new();
		clk                = 1'b0;
		arst_n             = 1'b0;
		steady             = 1'b0;
		hold_off           = 0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		frame_if.valid     = 1'b0;
		frame_if.current_a = '0;
		frame_if.current_b = '0;
		frame_if.current_c = '0;
		frame_if.current_n = '0;
		frame_if.dt_us     = '0;
		result_if.ready    = 1'b0;
		foreach (pick_now[i]) pick_now[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults with all phases on, one phase with zero pickup
		write_reg(CFG_ENABLE, 64'hF);
		write_reg(CFG_PICKUP, {16'hFFFF, 16'd0, 16'd1, 16'd1000});
		send_frame(16'd0, 16'd0, 16'd0, 16'd0, 20'd1000);
		send_frame(16'd1000, 16'd1, 16'd5, 16'hFFFF, 20'd1000);
		send_frame(16'd1000, 16'hFFFF, 16'd0, 16'hFFFE, 20'hFFFFF);
		send_frame(16'd1001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
		send_frame(16'd5000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'd0);
		send_frame(16'd5000, 16'd2, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
		send_frame(16'd20000, 16'd2, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
		send_frame(16'd999, 16'd1, 16'h0, 16'h0, 20'hFFFFF);
		drain();
		// extreme curve, clamps and huge multiples
		write_reg(CFG_CURVE, 64'hFFFFFF);
		write_reg(CFG_EXPONENT, 64'hFFFFF);
		write_reg(CFG_TMS, 64'hFFFFF);
		write_reg(CFG_MIN, 64'd500);
		write_reg(CFG_MAX, 64'hFFFF_FFFF);
		write_reg(CFG_PICKUP, {16'd1, 16'd1, 16'd2, 16'd30000});
		send_frame(16'd30004, 16'hFFFF, 16'h3, 16'hFFFF, 20'd1);
		send_frame(16'hFFFF, 16'hFFFF, 16'h3, 16'hFFFF, 20'hFFFFF);
		send_frame(16'hFFFF, 16'h2, 16'h2, 16'h1, 20'd300);
		drain();
		write_reg(CFG_CURVE, 64'd0);
		write_reg(CFG_EXPONENT, 64'd1);
		write_reg(CFG_MIN, 64'd0);
		write_reg(CFG_MAX, 64'd1);
		send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'd7);
		drain();
		write_reg(CFG_CURVE, 64'd9175);
		write_reg(CFG_TMS, 64'd0);
		send_frame(16'hFFFF, 16'h5555, 16'hAAAA, 16'hFFFF, 20'h55555);
		drain();
		write_reg(CFG_TMS, 64'd65536);
		write_reg(CFG_ENABLE, 64'd0);
		send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hAAAAA);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			random_settings();
			steady = (phase == 2);
			for (int k = 0; k < 190; k++) begin
				if (phase == 3 && k == 20) hold_off = 4000;
				send_frame(pick_current(pick_now[0]), pick_current(pick_now[1]),
					pick_current(pick_now[2]), pick_current(pick_now[3]), pick_dt());
			end
			drain();
		end
		steady = 1'b0;

		repeat (1000) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
